FILE: hw/rtl/rrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_pkg: shared types and constants of the raster rectangle blitter
// Store geometry, field widths, command kinds, CSR indexes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = XW + YW;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   localparam int FLD_W      = 12;   // coordinate and size fields
   localparam int CRD_W      = 13;   // coordinates after offsets and sums
   localparam int REG_DIM_W  = 11;   // active width / height registers
   localparam int COLOR_W    = 32;
   localparam int ROWS_W     = 13;   // signed scroll amount
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [REG_DIM_W-1:0] RESET_WIDTH  = 11'd1024;
   localparam logic [REG_DIM_W-1:0] RESET_HEIGHT = 11'd768;

   typedef enum logic [2:0] {
      KIND_HLINE, KIND_VLINE, KIND_OUTLINE, KIND_FILL,
      KIND_COPY, KIND_SCROLL, KIND_READ, KIND_WRITE
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FB_PRESENT, CSR_ACTIVE_WIDTH, CSR_ACTIVE_HEIGHT, CSR_BLANK_COLOR
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_LOAD, ST_CHECK, ST_FILL,
      ST_CP_RD, ST_CP_WR, ST_PX_RD, ST_PX_CAP, ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;     // latch a new transaction
      logic load_pass;  // clip and load the current pass
      logic next_pass;  // advance the pass index
      logic step;       // advance the walker by one pixel
      logic src_rd;     // read the copy source pixel
      logic dst_wr;     // write the destination pixel
      logic px_rd;      // read the single pixel of a read command
      logic px_cap;     // capture the read result
   } dp_cmd_type;

   typedef struct packed {
      logic fb_present;
      logic is_read;
      logic pass_empty;
      logic pass_last;
      logic pass_copy;
      logic walk_done;
   } dp_status_type;

endpackage

FILE: hw/rtl/rrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_ctrl: blitter sequencer
// Accepts commands, runs each pass of a command through the datapath walker
// and presents the single response.
// ----------------------------------------------------------------------------
module rrb_ctrl import rrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.fb_present) begin
               state_in = ST_RESP;
            end else if (status.is_read) begin
               state_in = ST_PX_RD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_pass = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.pass_empty) begin
               if (status.pass_last) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.next_pass = 1'b1;
                  state_in      = ST_LOAD;
               end
            end else if (status.pass_copy) begin
               state_in = ST_CP_RD;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.dst_wr = 1'b1;
            cmd.step   = 1'b1;
            if (status.walk_done) begin
               if (status.pass_last) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.next_pass = 1'b1;
                  state_in      = ST_LOAD;
               end
            end
         end
         ST_CP_RD: begin
            cmd.src_rd = 1'b1;
            state_in   = ST_CP_WR;
         end
         ST_CP_WR: begin
            cmd.dst_wr = 1'b1;
            cmd.step   = 1'b1;
            if (status.walk_done) begin
               if (status.pass_last) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.next_pass = 1'b1;
                  state_in      = ST_LOAD;
               end
            end else begin
               state_in = ST_CP_RD;
            end
         end
         ST_PX_RD: begin
            cmd.px_rd = 1'b1;
            state_in  = ST_PX_CAP;
         end
         ST_PX_CAP: begin
            cmd.px_cap = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accepting while a response is pending");

   a_copy_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CP_RD |=> state_ff == ST_CP_WR)
      else $error("copy read not followed by its write");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_DECODE)
      else $error("accepted transaction not decoded");

   a_read_capture: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PX_RD |=> cmd.px_cap)
      else $error("pixel read not captured");

endmodule

FILE: hw/rtl/rrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_datapath: configuration, pixel store and rectangle walker
// Holds the latched command, builds and clips each pass, walks it one pixel
// per step and reads and writes the pixel store.
// ----------------------------------------------------------------------------
module rrb_datapath import rrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [2:0]            req_kind,
   input  logic [FLD_W-1:0]      req_dest_x,
   input  logic [FLD_W-1:0]      req_dest_y,
   input  logic [FLD_W-1:0]      req_source_x,
   input  logic [FLD_W-1:0]      req_source_y,
   input  logic [FLD_W-1:0]      req_span_width,
   input  logic [FLD_W-1:0]      req_span_height,
   input  logic [COLOR_W-1:0]    req_paint_color,
   input  logic signed [ROWS_W-1:0] req_scroll_rows,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [COLOR_W-1:0]    rsp_pixel_value
);

   // configuration
   logic                 fb_present_ff;
   logic [REG_DIM_W-1:0] width_ff, height_ff;
   logic [COLOR_W-1:0]   blank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_present_ff <= 1'b0;
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         blank_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FB_PRESENT:    fb_present_ff <= csr_wdata[0];
            CSR_ACTIVE_WIDTH:  width_ff      <= csr_wdata[REG_DIM_W-1:0];
            CSR_ACTIVE_HEIGHT: height_ff     <= csr_wdata[REG_DIM_W-1:0];
            CSR_BLANK_COLOR:   blank_ff      <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // visible area, clamped to the store
   logic [CRD_W-1:0] vis_w, vis_h;
   assign vis_w = ({2'b0, width_ff} > CRD_W'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH)
                                                         : {2'b0, width_ff};
   assign vis_h = ({2'b0, height_ff} > CRD_W'(MAX_HEIGHT)) ? CRD_W'(MAX_HEIGHT)
                                                           : {2'b0, height_ff};

   // latched transaction
   kind_type          kind_ff;
   logic [CRD_W-1:0]  x_ff, y_ff, sx_ff, sy_ff, w_ff, h_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [1:0]        pass_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= kind_type'(req_kind);
         x_ff     <= {1'b0, req_dest_x};
         y_ff     <= {1'b0, req_dest_y};
         sx_ff    <= {1'b0, req_source_x};
         sy_ff    <= {1'b0, req_source_y};
         w_ff     <= {1'b0, req_span_width};
         h_ff     <= {1'b0, req_span_height};
         color_ff <= req_paint_color;
         rows_ff  <= req_scroll_rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else if (cmd.accept) begin
         pass_ff <= '0;
      end else if (cmd.next_pass) begin
         pass_ff <= pass_ff + 2'd1;
      end
   end

   // scroll amount
   logic             scr_zero, scr_up, scr_full;
   logic [CRD_W-1:0] scr_n, scr_rest;
   assign scr_zero = (rows_ff == '0);
   assign scr_up   = !rows_ff[ROWS_W-1];
   assign scr_n    = scr_up ? {1'b0, rows_ff[ROWS_W-2:0]} : (CRD_W'(0) - rows_ff);
   assign scr_full = (scr_n >= vis_h);
   assign scr_rest = vis_h - scr_n;

   // pass descriptor
   logic             p_copy, p_last;
   logic [CRD_W-1:0] p_dx, p_dy, p_sx, p_sy, p_w, p_h;
   logic [COLOR_W-1:0] p_color;

   always_comb begin
      p_copy  = 1'b0;
      p_last  = (pass_ff == 2'd0);
      p_dx    = x_ff;
      p_dy    = y_ff;
      p_sx    = sx_ff;
      p_sy    = sy_ff;
      p_w     = w_ff;
      p_h     = h_ff;
      p_color = color_ff;
      case (kind_ff)
         KIND_HLINE: p_h = CRD_W'(1);
         KIND_VLINE: p_w = CRD_W'(1);
         KIND_OUTLINE: begin
            p_last = (pass_ff == 2'd3);
            case (pass_ff)
               2'd0: p_h = CRD_W'(1);
               2'd1: begin
                  // bottom edge, absent for zero height
                  p_dy = y_ff + h_ff - CRD_W'(1);
                  p_h  = (h_ff == '0) ? '0 : CRD_W'(1);
               end
               2'd2: p_w = CRD_W'(1);
               default: begin
                  p_dx = x_ff + w_ff - CRD_W'(1);
                  p_w  = (w_ff == '0) ? '0 : CRD_W'(1);
               end
            endcase
         end
         KIND_FILL: ;
         KIND_COPY: p_copy = 1'b1;
         KIND_SCROLL: begin
            p_color = blank_ff;
            p_w     = vis_w;
            p_dx    = '0;
            p_sx    = '0;
            if (scr_zero) begin
               p_w = '0;
            end else if (scr_full) begin
               p_dy = '0;
               p_h  = vis_h;
            end else begin
               p_last = (pass_ff == 2'd1);
               if (pass_ff == 2'd0) begin
                  p_copy = 1'b1;
                  p_h    = scr_rest;
                  p_sy   = scr_up ? scr_n : '0;
                  p_dy   = scr_up ? '0 : scr_n;
               end else begin
                  p_h  = scr_n;
                  p_dy = scr_up ? scr_rest : '0;
               end
            end
         end
         default: begin
            // single pixel write
            p_w = CRD_W'(1);
            p_h = CRD_W'(1);
         end
      endcase
   end

   // clip
   logic             c_off, c_back;
   logic [CRD_W-1:0] c_cols, c_rows, c_wrem, c_hrem;
   assign c_off  = (p_dx >= vis_w) || (p_dy >= vis_h);
   assign c_wrem = vis_w - p_dx;
   assign c_hrem = vis_h - p_dy;
   assign c_cols = (p_w > c_wrem) ? c_wrem : p_w;
   assign c_rows = (p_h > c_hrem) ? c_hrem : p_h;
   assign c_back = p_copy && !((p_dy < p_sy) || ((p_dy == p_sy) && (p_dx < p_sx)));

   // walker
   logic             empty_ff, copy_ff, back_ff;
   logic [CRD_W-1:0] cols_ff, rows_cnt_ff, k_ff, r_ff;
   logic [CRD_W-1:0] dx_ff, dy_ff, sxc_ff, syc_ff, line_dx_ff, line_sx_ff;
   logic [COLOR_W-1:0] pcolor_ff;
   logic             col_last, row_last;

   assign col_last = (k_ff == cols_ff - CRD_W'(1));
   assign row_last = (r_ff == rows_cnt_ff - CRD_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.load_pass) begin
         empty_ff    <= c_off || (p_w == '0) || (p_h == '0);
         copy_ff     <= p_copy;
         back_ff     <= c_back;
         cols_ff     <= c_cols;
         rows_cnt_ff <= c_rows;
         pcolor_ff   <= p_color;
         k_ff        <= '0;
         r_ff        <= '0;
         if (c_back) begin
            line_dx_ff <= p_dx + c_cols - CRD_W'(1);
            line_sx_ff <= p_sx + c_cols - CRD_W'(1);
            dx_ff      <= p_dx + c_cols - CRD_W'(1);
            sxc_ff     <= p_sx + c_cols - CRD_W'(1);
            dy_ff      <= p_dy + c_rows - CRD_W'(1);
            syc_ff     <= p_sy + c_rows - CRD_W'(1);
         end else begin
            line_dx_ff <= p_dx;
            line_sx_ff <= p_sx;
            dx_ff      <= p_dx;
            sxc_ff     <= p_sx;
            dy_ff      <= p_dy;
            syc_ff     <= p_sy;
         end
      end else if (cmd.step) begin
         if (col_last) begin
            k_ff   <= '0;
            r_ff   <= r_ff + CRD_W'(1);
            dx_ff  <= line_dx_ff;
            sxc_ff <= line_sx_ff;
            dy_ff  <= back_ff ? dy_ff - CRD_W'(1) : dy_ff + CRD_W'(1);
            syc_ff <= back_ff ? syc_ff - CRD_W'(1) : syc_ff + CRD_W'(1);
         end else begin
            k_ff   <= k_ff + CRD_W'(1);
            dx_ff  <= back_ff ? dx_ff - CRD_W'(1) : dx_ff + CRD_W'(1);
            sxc_ff <= back_ff ? sxc_ff - CRD_W'(1) : sxc_ff + CRD_W'(1);
         end
      end
   end

   // pixel store
   logic [COLOR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [COLOR_W-1:0] wr_data, rd_data_ff, result_ff;
   logic               rd_ok, rd_ok_ff;

   assign wr_addr = {dy_ff[YW-1:0], dx_ff[XW-1:0]};
   assign rd_addr = cmd.px_rd ? {y_ff[YW-1:0], x_ff[XW-1:0]}
                              : {syc_ff[YW-1:0], sxc_ff[XW-1:0]};
   assign rd_ok   = cmd.px_rd ? ((x_ff < vis_w) && (y_ff < vis_h))
                              : ((sxc_ff < vis_w) && (syc_ff < vis_h));
   assign wr_data = copy_ff ? (rd_ok_ff ? rd_data_ff : '0) : pcolor_ff;

   always_ff @(posedge clock) begin
      if (cmd.dst_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.src_rd || cmd.px_rd) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         result_ff <= '0;
      end else if (cmd.px_cap) begin
         result_ff <= rd_ok_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_pixel_value   = result_ff;
   assign status.fb_present = fb_present_ff;
   assign status.is_read    = (kind_ff == KIND_READ);
   assign status.pass_empty = empty_ff;
   assign status.pass_last  = p_last;
   assign status.pass_copy  = copy_ff;
   assign status.walk_done  = col_last && row_last;

endmodule

FILE: hw/rtl/raster_rect_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_rect_blitter: 2D fill, copy, scroll and pixel access engine
// Top level: sequencer plus datapath around a 1M x 32 pixel store.
// ----------------------------------------------------------------------------
// One transaction at a time: a command is taken, run to completion and its
// single response (pixel_value, 0 except for an on-screen read) is held until
// taken; only then is the next command accepted. The walker moves one pixel
// per cycle for fills and lines; for copies each pixel is a read of the source,
// then a write of the destination through the single-port store.
// A command runs accept, decode and response; each pass runs load and clip,
// check, then a walk of its clipped area (skipped for a pass clipped away).
// An outline runs four passes; a scroll one copy and one fill pass, or a
// single pass (a fill when it reaches the visible height, empty at zero).
// A read runs accept, decode, pixel read, capture and response. The store
// has no reset and is not cleared; read only pixels that were drawn.
// Configuration writes take effect at once and belong between transactions.
// ----------------------------------------------------------------------------
module raster_rect_blitter import rrb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_kind,
   input  logic [FLD_W-1:0]         req_dest_x,
   input  logic [FLD_W-1:0]         req_dest_y,
   input  logic [FLD_W-1:0]         req_source_x,
   input  logic [FLD_W-1:0]         req_source_y,
   input  logic [FLD_W-1:0]         req_span_width,
   input  logic [FLD_W-1:0]         req_span_height,
   input  logic [COLOR_W-1:0]       req_paint_color,
   input  logic signed [ROWS_W-1:0] req_scroll_rows,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COLOR_W-1:0]       rsp_pixel_value
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence passes and the handshake
   rrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold configuration, clip passes, walk pixels, own the store
   rrb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_kind        (req_kind),
      .req_dest_x      (req_dest_x),
      .req_dest_y      (req_dest_y),
      .req_source_x    (req_source_x),
      .req_source_y    (req_source_y),
      .req_span_width  (req_span_width),
      .req_span_height (req_span_height),
      .req_paint_color (req_paint_color),
      .req_scroll_rows (req_scroll_rows),
      .cmd             (cmd),
      .status          (status),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule
